/* sv/shared_array_multi_stack_core_assert.svh */
// Assertion macros shared by the multi-stack RTL.
// Included by the top level; it depends on nothing else.
`ifndef SHARED_ARRAY_MULTI_STACK_CORE_ASSERT_SVH
`define SHARED_ARRAY_MULTI_STACK_CORE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define SAMS_ASSERT_ALWAYS(name, ck, rn, cond, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);

// A condition that must hold whenever the antecedent holds.
`define SAMS_ASSERT_IMPLY(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* sv/sams_pkg.sv */
// Shared types and constants of the multi-stack block.
// Used by sams_cell and shared_array_multi_stack_core; depends on nothing.
package sams_pkg;

    // Default geometry.
    localparam int PER_STACK_DEPTH_DEF = 16;
    localparam int STACK_COUNT_DEF     = 3;

    // Field widths.
    localparam int CMD_W    = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Per-cycle control of one storage cell.
    typedef struct packed {
        logic shift;   // take the word of the cell below
        logic write;   // take the pushed word
        logic read;    // drive the held word onto the read bus
    } cell_ctl_t;

endpackage

/* sv/sams_cell.sv */
// One word cell of the shared stack memory row.
// Depends on sams_pkg for the word width and the cell control struct.
module sams_cell (
    input  logic                      clk,
    input  sams_pkg::cell_ctl_t       ctl,
    input  logic [sams_pkg::WORD_W-1:0] lower_word,
    input  logic [sams_pkg::WORD_W-1:0] write_word,
    output logic [sams_pkg::WORD_W-1:0] word,
    output logic [sams_pkg::WORD_W-1:0] read_word
);
    import sams_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    // A push write wins over a shift; otherwise the cell holds its word.
    always_comb
    begin
        word_next = word_reg;
        if (ctl.write)
        begin
            word_next = write_word;
        end
        else if (ctl.shift)
        begin
            word_next = lower_word;
        end
    end

    // Storage has no reset: a word is undefined until written.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // The selected cell puts its word on the OR-combined read bus.
    assign word      = word_reg;
    assign read_word = ctl.read ? word_reg : '0;

endmodule

/* sv/shared_array_multi_stack_core.sv */
// Top level of the multi-stack block: stack bookkeeping, control and the cell row.
// Depends on sams_pkg, sams_cell and shared_array_multi_stack_core_assert.svh.

// Several stacks share one circular row of word cells, STACK_COUNT * PER_STACK_DEPTH
// deep. Every request passes through the EXEC state, which updates the stack
// registers and moves the cell row, and then the READ state, which reads the top
// word through the OR-combined read bus into the result register. A push onto a
// full stack that borrows a slot costs nothing extra, because every cell in the
// moved range takes the word of the cell below it in the same cycle. A new request
// is taken in the cycle its predecessor's result is registered, so the block does
// not take a new request before it is through with the last one, and a stalled
// result side holds it back. There is no clearing pass after reset.
module shared_array_multi_stack_core #(
    parameter int PER_STACK_DEPTH = sams_pkg::PER_STACK_DEPTH_DEF,
    parameter int STACK_COUNT     = sams_pkg::STACK_COUNT_DEF,
    localparam int ID_W = ($clog2(STACK_COUNT) > 2) ? $clog2(STACK_COUNT) : 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Request channel
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  logic [sams_pkg::CMD_W-1:0]         command,
    input  logic [ID_W-1:0]                    stack_id,
    input  logic signed [sams_pkg::WORD_W-1:0] value,
    // Result channel
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic signed [sams_pkg::WORD_W-1:0] data,
    output logic [sams_pkg::STATUS_W-1:0]      status,
    output logic                               now_empty,
    output logic                               now_full
);
    import sams_pkg::*;

    `include "shared_array_multi_stack_core_assert.svh"

    localparam int MEM_WORDS = STACK_COUNT * PER_STACK_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_WORDS);
    localparam int CNT_W     = $clog2(MEM_WORDS + 1);
    localparam int SID_W     = $clog2(STACK_COUNT);
    localparam int SUM_W     = CNT_W + SID_W;
    localparam logic [ADDR_W:0]   MEM_WORDS_A = (ADDR_W + 1)'(MEM_WORDS);
    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(MEM_WORDS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } fsm_t;

    // Registers and their next values.
    fsm_t                     state_reg, state_next;
    logic [CMD_W-1:0]         cmd_reg, cmd_next;
    logic [ID_W-1:0]          id_reg, id_next;
    logic [WORD_W-1:0]        value_reg, value_next;
    logic [ADDR_W-1:0]        start_reg [STACK_COUNT];
    logic [ADDR_W-1:0]        start_next [STACK_COUNT];
    logic [CNT_W-1:0]         size_reg [STACK_COUNT];
    logic [CNT_W-1:0]         size_next [STACK_COUNT];
    logic [CNT_W-1:0]         cap_reg [STACK_COUNT];
    logic [CNT_W-1:0]         cap_next [STACK_COUNT];
    logic                     rd_en_reg, rd_en_next;
    logic [ADDR_W-1:0]        rd_addr_reg, rd_addr_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic                     empty_reg, empty_next;
    logic                     full_reg, full_next;
    logic                     res_empty_reg, res_empty_next;
    logic                     res_full_reg, res_full_next;
    logic [STATUS_W-1:0]      res_status_reg, res_status_next;
    logic signed [WORD_W-1:0] data_reg, data_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    // Decode of the request held in the command registers.
    logic                     id_ok;
    logic [SID_W-1:0]         sid;
    logic [ADDR_W-1:0]        start_s;
    logic [CNT_W-1:0]         size_s;
    logic [CNT_W-1:0]         cap_s;
    logic [SUM_W-1:0]         total;
    logic                     is_push;
    logic                     is_pop;
    logic                     is_peek;
    logic                     mem_full;
    logic                     s_full;
    logic                     push_ok;
    logic                     pop_ok;
    logic                     read_ok;
    logic                     borrow;
    logic                     found;
    logic [SID_W-1:0]         donor;
    logic [SID_W-1:0]         donor_dist;
    logic [ADDR_W-1:0]        donor_start;
    logic [CNT_W-1:0]         donor_size;
    logic [ADDR_W-1:0]        lo;
    logic [ADDR_W:0]          end_sum;
    logic [ADDR_W-1:0]        end_addr;
    logic [ADDR_W-1:0]        shift_len;
    logic [ADDR_W:0]          wr_sum;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W:0]          rd_sum;
    logic [ADDR_W-1:0]        rd_addr;
    logic [CNT_W-1:0]         new_size_s;
    logic [CNT_W-1:0]         new_cap_s;
    logic [STATUS_W-1:0]      req_status;
    logic                     req_empty;
    logic                     req_full;

    // Handshake helpers.
    logic                     load_out;
    logic                     accept;

    // Cell row.
    cell_ctl_t                cell_ctl [MEM_WORDS];
    logic [WORD_W-1:0]        cell_word [MEM_WORDS];
    logic [WORD_W-1:0]        cell_rd [MEM_WORDS];
    logic [WORD_W-1:0]        rd_or;

    // Checks.
    logic [SUM_W-1:0]         cap_sum;
    logic                     size_over;

    // Handshake: a request is taken when idle, or while the last result is stored.
    assign load_out  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = !((state_reg == ST_IDLE) || ((state_reg == ST_READ) && load_out));
    assign accept    = cmd_valid && !cmd_stall;

    // Select the addressed stack and sum the stack sizes.
    always_comb
    begin
        id_ok   = {1'b0, id_reg} < (ID_W + 1)'(STACK_COUNT);
        sid     = id_reg[SID_W-1:0];
        start_s = '0;
        size_s  = '0;
        cap_s   = '0;
        total   = '0;
        for (int k = 0; k < STACK_COUNT; k++)
        begin
            if (SID_W'(k) == sid)
            begin
                start_s = start_reg[k];
                size_s  = size_reg[k];
                cap_s   = cap_reg[k];
            end
            total = total + SUM_W'(size_reg[k]);
        end
    end

    // Classify the request.
    always_comb
    begin
        is_push  = (cmd_reg == CMD_PUSH);
        is_pop   = (cmd_reg == CMD_POP);
        is_peek  = (cmd_reg == CMD_PEEK);
        mem_full = (total >= SUM_W'(MEM_WORDS));
        s_full   = (size_s >= cap_s);
        push_ok  = id_ok && is_push && !mem_full;
        read_ok  = id_ok && (is_pop || is_peek) && (size_s != '0);
        pop_ok   = read_ok && is_pop;
        borrow   = push_ok && s_full;
    end

    // Find the donor: the first following stack that is not full.
    always_comb
    begin
        int idx;
        found       = 1'b0;
        donor       = '0;
        donor_dist  = '0;
        donor_start = '0;
        donor_size  = '0;
        lo          = '0;
        for (int d = 1; d < STACK_COUNT; d++)
        begin
            idx = int'(sid) + d;
            if (idx >= STACK_COUNT)
            begin
                idx = idx - STACK_COUNT;
            end
            if (d == 1)
            begin
                lo = start_reg[idx];
            end
            if (!found && (size_reg[idx] < cap_reg[idx]))
            begin
                found       = 1'b1;
                donor       = SID_W'(idx);
                donor_dist  = SID_W'(d);
                donor_start = start_reg[idx];
                donor_size  = size_reg[idx];
            end
        end
    end

    // The moved range runs from the next stack's start to the slot above the donor's top word.
    always_comb
    begin
        end_sum  = {1'b0, donor_start} + (ADDR_W + 1)'(donor_size);
        end_addr = (end_sum >= MEM_WORDS_A) ? ADDR_W'(end_sum - MEM_WORDS_A)
                                            : end_sum[ADDR_W-1:0];
        if (end_addr >= lo)
        begin
            shift_len = end_addr - lo;
        end
        else
        begin
            shift_len = end_addr + ADDR_W'(MEM_WORDS) - lo;
        end
    end

    // Write slot for a push and top slot for a pop or peek.
    always_comb
    begin
        wr_sum  = {1'b0, start_s} + (ADDR_W + 1)'(size_s);
        wr_addr = (wr_sum >= MEM_WORDS_A) ? ADDR_W'(wr_sum - MEM_WORDS_A)
                                          : wr_sum[ADDR_W-1:0];
        rd_sum  = wr_sum - (ADDR_W + 1)'(1);
        rd_addr = (rd_sum >= MEM_WORDS_A) ? ADDR_W'(rd_sum - MEM_WORDS_A)
                                          : rd_sum[ADDR_W-1:0];
    end

    // Size and capacity of the addressed stack after the request.
    always_comb
    begin
        new_size_s = size_s;
        if (push_ok)
        begin
            new_size_s = size_s + CNT_W'(1);
        end
        else if (pop_ok)
        begin
            new_size_s = size_s - CNT_W'(1);
        end
        new_cap_s = borrow ? cap_s + CNT_W'(1) : cap_s;
    end

    // Result fields of the request, taken at the end of the update cycle.
    always_comb
    begin
        req_status = STATUS_OK;
        if (is_push && mem_full)
        begin
            req_status = STATUS_FULL;
        end
        else if ((is_pop || is_peek) && (size_s == '0))
        begin
            req_status = STATUS_EMPTY;
        end
        req_empty = (new_size_s == '0);
        req_full  = (new_size_s == new_cap_s);
        if (!id_ok)
        begin
            req_status = STATUS_OK;
            req_empty  = 1'b0;
            req_full   = 1'b0;
        end
    end

    // Next state of the stack registers, the sequencer and the result register.
    always_comb
    begin
        int kd;
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        value_next      = value_reg;
        start_next      = start_reg;
        size_next       = size_reg;
        cap_next        = cap_reg;
        rd_en_next      = rd_en_reg;
        rd_addr_next    = rd_addr_reg;
        res_status_next = res_status_reg;
        res_empty_next  = res_empty_reg;
        res_full_next   = res_full_reg;
        status_next     = status_reg;
        empty_next      = empty_reg;
        full_next       = full_reg;
        data_next       = data_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Update stack bookkeeping; the cell row moves in the same cycle.
                for (int k = 0; k < STACK_COUNT; k++)
                begin
                    kd = k - int'(sid);
                    if (kd < 0)
                    begin
                        kd = kd + STACK_COUNT;
                    end
                    if (borrow && (kd >= 1) && (kd <= int'(donor_dist)))
                    begin
                        start_next[k] = (start_reg[k] == LAST_ADDR) ? '0
                                                                    : start_reg[k] + ADDR_W'(1);
                    end
                    if (borrow && (SID_W'(k) == donor))
                    begin
                        cap_next[k] = cap_reg[k] - CNT_W'(1);
                    end
                    if (SID_W'(k) == sid)
                    begin
                        if (push_ok || pop_ok)
                        begin
                            size_next[k] = new_size_s;
                        end
                        if (borrow)
                        begin
                            cap_next[k] = new_cap_s;
                        end
                    end
                end
                rd_en_next      = read_ok;
                rd_addr_next    = rd_addr;
                res_status_next = req_status;
                res_empty_next  = req_empty;
                res_full_next   = req_full;
                state_next      = ST_READ;
            end
            ST_READ:
            begin
                // The whole result moves to the output registers together.
                if (load_out)
                begin
                    data_next      = rd_en_reg ? rd_or : '0;
                    status_next    = res_status_reg;
                    empty_next     = res_empty_reg;
                    full_next      = res_full_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = accept ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Capture a new request.
        if (accept)
        begin
            cmd_next   = command;
            id_next    = stack_id;
            value_next = value;
        end
    end

    // State, stack registers and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= '0;
            id_reg         <= '0;
            value_reg      <= '0;
            for (int k = 0; k < STACK_COUNT; k++)
            begin
                start_reg[k] <= ADDR_W'(k * PER_STACK_DEPTH);
                size_reg[k]  <= '0;
                cap_reg[k]   <= CNT_W'(PER_STACK_DEPTH);
            end
            rd_en_reg      <= 1'b0;
            rd_addr_reg    <= '0;
            res_status_reg <= STATUS_OK;
            res_empty_reg  <= 1'b0;
            res_full_reg   <= 1'b0;
            status_reg     <= STATUS_OK;
            empty_reg      <= 1'b0;
            full_reg       <= 1'b0;
            data_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            id_reg         <= id_next;
            value_reg      <= value_next;
            start_reg      <= start_next;
            size_reg       <= size_next;
            cap_reg        <= cap_next;
            rd_en_reg      <= rd_en_next;
            rd_addr_reg    <= rd_addr_next;
            res_status_reg <= res_status_next;
            res_empty_reg  <= res_empty_next;
            res_full_reg   <= res_full_next;
            status_reg     <= status_next;
            empty_reg      <= empty_next;
            full_reg       <= full_next;
            data_reg       <= data_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Per-cell control: shift inside the moved range, write the push slot, read the top.
    always_comb
    begin
        logic [ADDR_W-1:0] off;
        for (int i = 0; i < MEM_WORDS; i++)
        begin
            if (ADDR_W'(i) >= lo)
            begin
                off = ADDR_W'(i) - lo;
            end
            else
            begin
                off = ADDR_W'(i) + ADDR_W'(MEM_WORDS) - lo;
            end
            cell_ctl[i].shift = (state_reg == ST_EXEC) && borrow &&
                                (off != '0) && (off <= shift_len);
            cell_ctl[i].write = (state_reg == ST_EXEC) && push_ok &&
                                (ADDR_W'(i) == wr_addr);
            cell_ctl[i].read  = (ADDR_W'(i) == rd_addr_reg);
        end
    end

    // The row of cells; each one takes its lower neighbor's word on a shift.
    for (genvar g = 0; g < MEM_WORDS; g++)
    begin : g_cell
        localparam int LOWER = (g == 0) ? MEM_WORDS - 1 : g - 1;
        sams_cell u_cell (
            .clk        (clk),
            .ctl        (cell_ctl[g]),
            .lower_word (cell_word[LOWER]),
            .write_word (value_reg),
            .word       (cell_word[g]),
            .read_word  (cell_rd[g])
        );
    end

    // Combine the read outputs; only the selected cell drives nonzero.
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < MEM_WORDS; i++)
        begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    // Outputs.
    assign rsp_valid = rsp_valid_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign now_empty = empty_reg;
    assign now_full  = full_reg;

    // Bookkeeping sums used by the checks below.
    always_comb
    begin
        cap_sum   = '0;
        size_over = 1'b0;
        for (int k = 0; k < STACK_COUNT; k++)
        begin
            cap_sum = cap_sum + SUM_W'(cap_reg[k]);
            if (size_reg[k] > cap_reg[k])
            begin
                size_over = 1'b1;
            end
        end
    end

    // Capacities always cover the whole cell row exactly.
    `SAMS_ASSERT_ALWAYS(a_cap_sum, clk, rst_n, cap_sum == SUM_W'(MEM_WORDS), "capacity sum broken")
    // No stack ever holds more words than its capacity.
    `SAMS_ASSERT_ALWAYS(a_size_cap, clk, rst_n, !size_over, "stack size above capacity")
    // A new result appears only at the end of the read cycle.
    `SAMS_ASSERT_IMPLY(a_rsp_src, clk, rst_n, $rose(rsp_valid_reg), $past(state_reg) == ST_READ, "result outside read cycle")

endmodule
